// ===== design/sdsd_pkg.sv =====
// Package for the slow-data segment demultiplexer: item types, command codes,
// segment type nibbles and result kind codes.
// Depends on nothing; the store, the top level and the checker import it.
package sdsd_pkg;

    // Input item and result item as they travel on the two channels.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] seg_byte0;
        logic [7:0] seg_byte1;
        logic [7:0] seg_byte2;
        logic [1:0] read_store;
        logic [7:0] read_index;
    } in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [5:0] msg_count;
        logic [8:0] gps_count;
        logic [6:0] header_count;
        logic [2:0] segment_kind;
        logic       overflow;
    } out_t;

    // Up to three payload bytes handed to a store in one item; entry 0 is
    // appended first.
    typedef logic [2:0][7:0] seg_bytes_t;

    // Per-store command from the decoder.
    typedef struct packed {
        logic       clear;
        logic [1:0] cnt;
    } st_cmd_t;

    // Item modes.
    localparam logic [1:0] MODE_SEGMENT = 2'd0;
    localparam logic [1:0] MODE_CLEAR   = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    // Store selectors for a read.
    localparam logic [1:0] STORE_MSG = 2'd0;
    localparam logic [1:0] STORE_GPS = 2'd1;
    localparam logic [1:0] STORE_HDR = 2'd2;

    // Segment type nibbles (high nibble of byte 0 on a first half).
    localparam logic [3:0] TYPE_MSG = 4'h4;
    localparam logic [3:0] TYPE_GPS = 4'h3;
    localparam logic [3:0] TYPE_HDR = 4'h5;
    localparam logic [3:0] TYPE_SQL = 4'h2;

    // A text message always carries this length.
    localparam logic [3:0] MSG_FIXED_LEN = 4'd5;

    // Reported kind codes.
    localparam logic [2:0] KIND_MSG     = 3'd0;
    localparam logic [2:0] KIND_GPS     = 3'd1;
    localparam logic [2:0] KIND_HDR     = 3'd2;
    localparam logic [2:0] KIND_SQL     = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN = 3'd4;

endpackage

// ===== design/sdsd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sdsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/sdsd_store.sv =====
// One byte store of the demultiplexer: three interleaved RAM banks so that up
// to three bytes are appended per item, plus fill tracking and read-out.
// Depends on sdsd_pkg and sdsd_ram.
module sdsd_store #(
    parameter int DEPTH = 32,
    localparam int FW = $clog2(DEPTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sdsd_pkg::st_cmd_t    cmd,
    input  sdsd_pkg::seg_bytes_t wr_bytes,
    input  logic [7:0]           rd_index,
    input  logic [7:0]           rsp_index,
    output logic [FW-1:0]        fill_next,
    output logic [7:0]           rd_data,
    output logic                 ovf
);
    import sdsd_pkg::*;

    // Byte position p lives in bank p mod 3, row p div 3.
    localparam int BANK_DEPTH = (DEPTH + 2) / 3;
    localparam int AW = $clog2(BANK_DEPTH);
    localparam int RW = $clog2(BANK_DEPTH + 1);

    logic [FW-1:0] fill_reg;
    logic [RW-1:0] row_reg, row_next;
    logic [1:0]    phase_reg, phase_next;

    logic [FW-1:0] space;
    logic [1:0]    n_ok;
    logic [2:0]    sum;

    logic [2:0]         we;
    logic [AW-1:0]      waddr [3];
    logic [7:0]         wdata [3];
    logic [7:0]         ram_q [3];
    logic [AW-1:0]      raddr;
    logic [16:0]        rd_prod;
    logic [16:0]        rsp_prod;
    logic [7:0]         rsp_row;
    logic [9:0]         rsp_row3;
    logic [1:0]         rsp_bank;
    logic [2:0]         byp_hit_reg;
    logic [7:0]         byp_data_reg [3];
    logic [7:0]         bank_data;

    always_comb begin
        space = FW'(DEPTH) - fill_reg;
        if (space >= FW'(cmd.cnt)) begin
            n_ok = cmd.cnt;
        end else begin
            n_ok = space[1:0];
        end
        ovf = space < FW'(cmd.cnt);
        sum = {1'b0, phase_reg} + {1'b0, n_ok};

        if (cmd.clear) begin
            fill_next  = '0;
            row_next   = '0;
            phase_next = '0;
        end else begin
            fill_next = fill_reg + FW'(n_ok);
            if (sum >= 3'd3) begin
                phase_next = 2'(sum - 3'd3);
                row_next   = row_reg + RW'(1);
            end else begin
                phase_next = sum[1:0];
                row_next   = row_reg;
            end
        end
    end

    // Bank j takes the byte at offset (j - phase) mod 3 of this item; banks
    // below the phase have already wrapped into the next row.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            logic [1:0] off;
            if (2'(j) >= phase_reg) begin
                off = 2'(j) - phase_reg;
            end else begin
                off = 2'(j) + 2'd3 - phase_reg;
            end
            we[j]    = off < n_ok;
            waddr[j] = AW'(row_reg + RW'(2'(j) < phase_reg));
            wdata[j] = wr_bytes[off];
        end
    end

    // Division by three through a reciprocal, exact for 8-bit indices.
    assign rd_prod  = 17'(rd_index) * 17'd171;
    assign raddr    = AW'(rd_prod[16:9]);
    assign rsp_prod = 17'(rsp_index) * 17'd171;
    assign rsp_row  = rsp_prod[16:9];
    assign rsp_row3 = {1'b0, rsp_row, 1'b0} + {2'b00, rsp_row};
    assign rsp_bank = 2'({2'b00, rsp_index} - rsp_row3);

    for (genvar g = 0; g < 3; g++) begin : g_bank
        sdsd_ram #(
            .WIDTH(8),
            .DEPTH(BANK_DEPTH)
        ) u_ram (
            .aclk (aclk),
            .we   (we[g]),
            .waddr(waddr[g]),
            .wdata(wdata[g]),
            .raddr(raddr),
            .rdata(ram_q[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            row_reg     <= '0;
            phase_reg   <= '0;
            byp_hit_reg <= '0;
        end else begin
            fill_reg  <= fill_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
            for (int j = 0; j < 3; j++) begin
                byp_hit_reg[j] <= we[j] && (waddr[j] == raddr);
            end
        end
        for (int j = 0; j < 3; j++) begin
            byp_data_reg[j] <= wdata[j];
        end
    end

    // A write in the same cycle as the read is forwarded. Positions at or past
    // the fill count read as zero whatever the RAMs hold, so they need no clearing.
    always_comb begin
        case (rsp_bank)
            2'd0:    bank_data = byp_hit_reg[0] ? byp_data_reg[0] : ram_q[0];
            2'd1:    bank_data = byp_hit_reg[1] ? byp_data_reg[1] : ram_q[1];
            2'd2:    bank_data = byp_hit_reg[2] ? byp_data_reg[2] : ram_q[2];
            default: bank_data = '0;
        endcase
        if (32'(rsp_index) < 32'(fill_reg)) begin
            rd_data = bank_data;
        end else begin
            rd_data = '0;
        end
    end

endmodule

// ===== design/slow_data_segment_demux.sv =====
// Top level of the slow-data segment demultiplexer: item decoder, half
// tracking and result register around three byte stores.
// Depends on sdsd_pkg and sdsd_store.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_valid / s_ready   s_item  (sdsd_pkg::in_t)
//   m_        out        m_valid / m_ready   m_item  (sdsd_pkg::out_t)
//
// An item is decoded and appended when it moves on from the input register;
// the store RAMs, addressed as it arrived and while it waited, then already
// give its read data, and the result is registered in the result register.
// Reset is synchronous and active low; fill counts mask unwritten positions,
// so no clearing pass runs. A stalled result holds the item in the input
// register, and a new item is taken in the cycle that the result is collected.
module slow_data_segment_demux #(
    parameter int MSG_DEPTH = 32,
    parameter int GPS_DEPTH = 256,
    parameter int HDR_DEPTH = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  sdsd_pkg::in_t   s_item,
    output logic            m_valid,
    input  logic            m_ready,
    output sdsd_pkg::out_t  m_item
);
    import sdsd_pkg::*;

    localparam int MSG_FW = $clog2(MSG_DEPTH + 1);
    localparam int GPS_FW = $clog2(GPS_DEPTH + 1);
    localparam int HDR_FW = $clog2(HDR_DEPTH + 1);

    // Input register.
    logic in_valid_reg;
    in_t  in_item_reg;

    // Result register.
    logic m_valid_reg;
    out_t m_item_reg;

    // Segment tracking state.
    logic       half_reg, half_next;
    logic [3:0] rem_reg, rem_next;
    logic [3:0] type_reg, type_next;

    logic       fire;
    logic       load;
    logic [7:0] rd_index_sel;
    logic       clr;
    logic [1:0] cnt;
    logic [3:0] len;
    seg_bytes_t bytes;

    st_cmd_t msg_cmd, gps_cmd, hdr_cmd;
    logic [MSG_FW-1:0] msg_fill_next;
    logic [GPS_FW-1:0] gps_fill_next;
    logic [HDR_FW-1:0] hdr_fill_next;
    logic [31:0] msg_fill32, gps_fill32, hdr_fill32;
    logic [7:0]  msg_rd, gps_rd, hdr_rd;
    logic        msg_ovf, gps_ovf, hdr_ovf;
    out_t        result;

    // The item in the input register moves on when the result register is
    // free or is being emptied in this cycle.
    assign fire    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign load    = s_valid && s_ready;

    // The RAMs are addressed by the arriving item, and by the held item while
    // it waits, so their read data always belongs to the input register.
    assign rd_index_sel = load ? s_item.read_index : in_item_reg.read_index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (load) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
        if (load) begin
            in_item_reg <= s_item;
        end
    end

    // Decode of a segment. A first half takes type and length (fixed for a text
    // message) from byte 0 and up to two bytes from bytes 1 and 2; a second half
    // takes up to three bytes of the remainder: the length less two, floored at zero.
    always_comb begin
        half_next = half_reg;
        rem_next  = rem_reg;
        type_next = type_reg;
        cnt       = 2'd0;
        len       = in_item_reg.seg_byte0[3:0];
        clr       = fire && (in_item_reg.mode == MODE_CLEAR);
        bytes[0]  = in_item_reg.seg_byte0;
        bytes[1]  = in_item_reg.seg_byte1;
        bytes[2]  = in_item_reg.seg_byte2;

        if (fire && (in_item_reg.mode == MODE_SEGMENT)) begin
            if (!half_reg) begin
                type_next = in_item_reg.seg_byte0[7:4];
                if (type_next == TYPE_MSG) begin
                    len = MSG_FIXED_LEN;
                end
                rem_next  = len;
                cnt       = (len < 4'd2) ? len[1:0] : 2'd2;
                bytes[0]  = in_item_reg.seg_byte1;
                bytes[1]  = in_item_reg.seg_byte2;
                bytes[2]  = 8'h00;
                half_next = 1'b1;
            end else begin
                rem_next  = (rem_reg > 4'd2) ? (rem_reg - 4'd2) : 4'd0;
                cnt       = (rem_next < 4'd3) ? rem_next[1:0] : 2'd3;
                half_next = 1'b0;
            end
        end

        // A clear always expects a first half next; type and remainder stay.
        if (clr) begin
            half_next = 1'b0;
        end

        msg_cmd.clear = clr;
        gps_cmd.clear = clr;
        hdr_cmd.clear = clr;
        msg_cmd.cnt   = (type_next == TYPE_MSG) ? cnt : 2'd0;
        gps_cmd.cnt   = (type_next == TYPE_GPS) ? cnt : 2'd0;
        hdr_cmd.cnt   = (type_next == TYPE_HDR) ? cnt : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg <= 1'b0;
            rem_reg  <= '0;
            type_reg <= '0;
        end else begin
            half_reg <= half_next;
            rem_reg  <= rem_next;
            type_reg <= type_next;
        end
    end

    sdsd_store #(.DEPTH(MSG_DEPTH)) u_msg_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (msg_cmd),
        .wr_bytes (bytes),
        .rd_index (rd_index_sel),
        .rsp_index(in_item_reg.read_index),
        .fill_next(msg_fill_next),
        .rd_data  (msg_rd),
        .ovf      (msg_ovf)
    );

    sdsd_store #(.DEPTH(GPS_DEPTH)) u_gps_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (gps_cmd),
        .wr_bytes (bytes),
        .rd_index (rd_index_sel),
        .rsp_index(in_item_reg.read_index),
        .fill_next(gps_fill_next),
        .rd_data  (gps_rd),
        .ovf      (gps_ovf)
    );

    sdsd_store #(.DEPTH(HDR_DEPTH)) u_hdr_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (hdr_cmd),
        .wr_bytes (bytes),
        .rd_index (rd_index_sel),
        .rsp_index(in_item_reg.read_index),
        .fill_next(hdr_fill_next),
        .rd_data  (hdr_rd),
        .ovf      (hdr_ovf)
    );

    // Fill counts are reported modulo their field widths.
    assign msg_fill32 = 32'(msg_fill_next);
    assign gps_fill32 = 32'(gps_fill_next);
    assign hdr_fill32 = 32'(hdr_fill_next);

    always_comb begin
        result.read_data = 8'h00;
        if (in_item_reg.mode == MODE_READ) begin
            case (in_item_reg.read_store)
                STORE_MSG: result.read_data = msg_rd;
                STORE_GPS: result.read_data = gps_rd;
                STORE_HDR: result.read_data = hdr_rd;
                default:   result.read_data = 8'h00;
            endcase
        end
        result.msg_count    = msg_fill32[5:0];
        result.gps_count    = gps_fill32[8:0];
        result.header_count = hdr_fill32[6:0];
        case (type_next)
            TYPE_MSG: result.segment_kind = KIND_MSG;
            TYPE_GPS: result.segment_kind = KIND_GPS;
            TYPE_HDR: result.segment_kind = KIND_HDR;
            TYPE_SQL: result.segment_kind = KIND_SQL;
            default:  result.segment_kind = KIND_UNKNOWN;
        endcase
        result.overflow = msg_ovf || gps_ovf || hdr_ovf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (fire) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== design/sdsd_checker.sv =====
// Port-level checks for the slow-data segment demultiplexer, bound to the
// top level. Depends on sdsd_pkg and slow_data_segment_demux.
module sdsd_checker #(
    parameter int MSG_DEPTH = 32,
    parameter int GPS_DEPTH = 256,
    parameter int HDR_DEPTH = 64
) (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input sdsd_pkg::out_t m_item
);
    import sdsd_pkg::*;

    // A result waiting for the sink holds still.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // Nothing is offered in the cycle after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Only a storing type can drop bytes.
    a_ovf_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.overflow |->
            (m_item.segment_kind == KIND_MSG) || (m_item.segment_kind == KIND_GPS)
            || (m_item.segment_kind == KIND_HDR))
        else $error("overflow on a non-storing type");

    // A dropped byte means the selected store is full.
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.overflow |->
            ((m_item.segment_kind == KIND_MSG) && (m_item.msg_count == 6'(MSG_DEPTH)))
            || ((m_item.segment_kind == KIND_GPS) && (m_item.gps_count == 9'(GPS_DEPTH)))
            || ((m_item.segment_kind == KIND_HDR)
                && (m_item.header_count == 7'(HDR_DEPTH))))
        else $error("overflow with a store that is not full");

    // An idle block with an empty pipeline is ready for an item.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !s_valid |=> s_ready)
        else $error("not ready with an empty pipeline");

endmodule

bind slow_data_segment_demux sdsd_checker #(
    .MSG_DEPTH(MSG_DEPTH),
    .GPS_DEPTH(GPS_DEPTH),
    .HDR_DEPTH(HDR_DEPTH)
) u_sdsd_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_item (m_item)
);
